// File: hw/rtl/hcp_pkg.sv
`default_nettype none

package hcp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;
	localparam int SYM_W        = $clog2(SYMBOL_COUNT);

	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int ACC_W   = 7;
	localparam int BUF_W   = ACC_W + CODE_W;
	localparam int WORD_W  = BUF_W + 1;
	localparam int ENTRY_W = LEN_W + CODE_W;
	localparam int BYTE_BITS = 8;

	// longest code actually appended
	localparam logic [LEN_W-1:0] USED_CAP =
		LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

	localparam logic [7:0] ESCAPE_RESET = 8'd26;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_ENCODE = 2'd1,
		MODE_FLUSH  = 2'd2
	} mode_t;

	// byte group handed from the merge stage to the emitter
	typedef struct packed {
		logic              load;
		logic [WORD_W-1:0] word;    // left aligned, first byte in the top bits
		logic [2:0]        nbytes;
		logic [2:0]        pad;
	} emit_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/hcp_ram.sv
`default_nettype none

module hcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/hcp_emit.sv
`default_nettype none

module hcp_emit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hcp_pkg::emit_req_t req,
	output logic                   free,
	input  wire logic [7:0]        escape,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             out_byte,
	output logic [31:0]            byte_position,
	output logic                   kept,
	output logic [2:0]             pad_bits,
	output logic                   last
);

	logic [2:0]                   left_q;
	logic [31:0]                  cnt_q;
	logic [hcp_pkg::WORD_W-1:0]   word_q;
	logic [2:0]                   pad_q;
	logic                         out_acc;

	assign out_acc = out_valid && !out_stall;
	// empty now, or the final byte leaves at this edge
	assign free    = (left_q == 3'd0) || ((left_q == 3'd1) && out_acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 3'd0;
			cnt_q  <= 32'd0;
		end else begin
			if (req.load) begin
				left_q <= req.nbytes;
			end else if (out_acc) begin
				left_q <= left_q - 3'd1;
			end
			if (out_acc) begin
				cnt_q <= cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			word_q <= req.word;
			pad_q  <= req.pad;
		end else if (out_acc) begin
			word_q <= word_q << hcp_pkg::BYTE_BITS;
		end
	end

	assign out_valid     = (left_q != 3'd0);
	assign out_byte      = word_q[hcp_pkg::WORD_W-1 -: 8];
	assign byte_position = cnt_q;
	assign kept          = (out_byte != escape);
	assign last          = (left_q == 3'd1);
	assign pad_bits      = last ? pad_q : 3'd0;

	a_pad_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pad_bits != 3'd0) |-> last)
		else $error("pad count shown on a byte that is not last");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("byte group ended early");

	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> byte_position == $past(byte_position) + 32'd1)
		else $error("byte position did not advance by one");

endmodule

`default_nettype wire

// File: hw/rtl/huffman_code_packer.sv
// Huffman code packer.
// Input channel (in_valid/in_stall): mode, symbol, code_bits, code_len. A load
// request writes the code table entry of symbol; an encode request appends
// that symbol's code MSB first behind the pending bits; a flush pads the
// pending bits with zeros to a byte boundary.
// Output channel (out_valid/out_stall): packed bytes, each with its
// stream position, kept (0 when the byte equals escape_value), pad_bits
// (flush only) and last on the final byte caused by a request.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes escape_value; write
// it only while the block is idle. cfg_ready is always high.
// Path: the table read is registered at the edge that takes a request; the
// merge then loads the emitter once it is free, which shows the first byte.
// Throughput: a request that yields k bytes (up to 4 for an encode, 1 for a
// flush) holds the emitter until they have left, and the next request is taken
// meanwhile; loads, empty codes and aligned flushes go one per cycle unless
// a waiting byte group holds them. While out_stall is high the pending bytes
// hold; the next request still merges unless it yields bytes, and in_stall
// rises only once a finished byte group waits for the emitter.
// Reset clears accumulator, pending count and byte position, loads
// escape_value 26; the code table is not cleared and must be loaded.
`default_nettype none

module huffman_code_packer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  symbol,
	input  wire logic [31:0] code_bits,
	input  wire logic [5:0]  code_len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [31:0]      byte_position,
	output logic             kept,
	output logic [2:0]       pad_bits,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0]                    escape_q;
	logic [hcp_pkg::ACC_W-1:0]     acc_q;
	logic [2:0]                    pend_q;
	logic                          valid_s1;
	logic [1:0]                    mode_s1;
	logic                          ok_s1;

	logic                          in_acc;
	logic                          in_range;
	logic [hcp_pkg::ENTRY_W-1:0]   rdata;
	logic                          emit_free;
	logic                          adv_s1;
	hcp_pkg::emit_req_t            req;

	// merge stage signals
	logic [hcp_pkg::LEN_W-1:0]     len_raw;
	logic [hcp_pkg::LEN_W-1:0]     ul;
	logic [hcp_pkg::CODE_W:0]      mask;
	logic [hcp_pkg::CODE_W-1:0]    code;
	logic [hcp_pkg::BUF_W-1:0]     bitbuf;
	logic [hcp_pkg::LEN_W-1:0]     total;
	logic [7:0]                    rem_mask;
	logic [7:0]                    flush_byte;
	logic [3:0]                    flush_pad;
	logic [2:0]                    nbytes;
	logic [hcp_pkg::WORD_W-1:0]    word;
	logic [2:0]                    pad;
	logic [hcp_pkg::ACC_W-1:0]     acc_next;
	logic [2:0]                    pend_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= hcp_pkg::ESCAPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			escape_q <= cfg_data;
		end
	end

	assign in_acc   = in_valid && !in_stall;
	assign in_range = (9'(symbol) < 9'(hcp_pkg::SYMBOL_COUNT));

	// code table: {length, code bits}; a load writes at acceptance, every
	// request reads, so a following encode already sees the new entry
	hcp_ram #(
		.WIDTH(hcp_pkg::ENTRY_W),
		.DEPTH(hcp_pkg::SYMBOL_COUNT)
	) u_table (
		.clk  (clk),
		.we   (in_acc && (mode == hcp_pkg::MODE_LOAD) && in_range),
		.waddr(symbol[hcp_pkg::SYM_W-1:0]),
		.wdata({code_len, code_bits}),
		.re   (in_acc),
		.raddr(symbol[hcp_pkg::SYM_W-1:0]),
		.rdata(rdata)
	);

	// merge: code joins the accumulator, whole bytes go to the emitter,
	// the remainder stays in the accumulator
	always_comb begin
		len_raw    = rdata[hcp_pkg::ENTRY_W-1 -: hcp_pkg::LEN_W];
		ul         = (len_raw > hcp_pkg::USED_CAP) ? hcp_pkg::USED_CAP : len_raw;
		mask       = ((hcp_pkg::CODE_W+1)'(1) << ul) - (hcp_pkg::CODE_W+1)'(1);
		code       = rdata[hcp_pkg::CODE_W-1:0] & mask[hcp_pkg::CODE_W-1:0];
		bitbuf     = (hcp_pkg::BUF_W'(acc_q) << ul) | hcp_pkg::BUF_W'(code);
		total      = hcp_pkg::LEN_W'(pend_q) + ul;
		rem_mask   = (8'd1 << total[2:0]) - 8'd1;
		flush_pad  = 4'd8 - 4'(pend_q);
		flush_byte = 8'(acc_q) << flush_pad;

		nbytes    = 3'd0;
		word      = '0;
		pad       = 3'd0;
		acc_next  = acc_q;
		pend_next = pend_q;
		case (mode_s1)
			hcp_pkg::MODE_ENCODE: begin
				if (ok_s1) begin
					nbytes    = total[5:3];
					word      = hcp_pkg::WORD_W'(bitbuf)
						<< (hcp_pkg::LEN_W'(hcp_pkg::WORD_W) - total);
					acc_next  = bitbuf[hcp_pkg::ACC_W-1:0] & rem_mask[hcp_pkg::ACC_W-1:0];
					pend_next = total[2:0];
				end
			end
			hcp_pkg::MODE_FLUSH: begin
				if (pend_q != 3'd0) begin
					nbytes    = 3'd1;
					word      = {flush_byte, {(hcp_pkg::WORD_W-8){1'b0}}};
					pad       = flush_pad[2:0];
					acc_next  = '0;
					pend_next = 3'd0;
				end
			end
			default: begin
			end
		endcase
	end

	// a group that yields bytes waits for the emitter to drain
	assign adv_s1   = valid_s1 && ((nbytes == 3'd0) || emit_free);
	assign in_stall = valid_s1 && !adv_s1;

	assign req.load   = valid_s1 && (nbytes != 3'd0) && emit_free;
	assign req.word   = word;
	assign req.nbytes = nbytes;
	assign req.pad    = pad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			pend_q   <= 3'd0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				acc_q  <= acc_next;
				pend_q <= pend_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= mode;
			ok_s1   <= in_range;
		end
	end

	hcp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.free         (emit_free),
		.escape       (escape_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_position(byte_position),
		.kept         (kept),
		.pad_bits     (pad_bits),
		.last         (last)
	);

	a_stall_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with nothing blocking it");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1 && $stable(acc_q) && $stable(pend_q))
		else $error("merge stage state moved while stalled");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (mode_s1 == hcp_pkg::MODE_FLUSH) |=> pend_q == 3'd0)
		else $error("flush left pending bits");

endmodule

`default_nettype wire

// File: sim/testbench.sv
module testbench;

	// Mode 3 has no meaning; the block must drop it without output.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Longest code that actually gets appended; longer lengths are clipped.
	localparam int CODE_CAP = (hcp_pkg::MAX_CODE_LEN < hcp_pkg::CODE_W) ?
		hcp_pkg::MAX_CODE_LEN : hcp_pkg::CODE_W;

	// Quiet cycles allowed before the block is declared hung. The worst honest gap
	// is an input pause, the pipeline, and a full stall burst.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles to let a request with no output clear the pipeline before a config write.
	localparam int SETTLE_CYCLES  = 8;
	// Extra cycles after the last expected byte, to catch stray output.
	localparam int DRAIN_CYCLES   = 16;

	// One packed byte as the output port should present it.
	typedef struct packed {
		logic [7:0]  data;
		logic [31:0] pos;
		logic        kept;
		logic [2:0]  pad;
		logic        last;
	} packed_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  symbol;
	logic [31:0] code_bits;
	logic [5:0]  code_len;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic [31:0] byte_position;
	logic        kept;
	logic [2:0]  pad_bits;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	huffman_code_packer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.symbol        (symbol),
		.code_bits     (code_bits),
		.code_len      (code_len),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_position (byte_position),
		.kept          (kept),
		.pad_bits      (pad_bits),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Shadow of the packer: its own code table, bit accumulator and stream position.
	logic [31:0] tbl_code [hcp_pkg::SYMBOL_COUNT];
	logic [5:0]  tbl_len  [hcp_pkg::SYMBOL_COUNT];
	logic [6:0]  acc_bits      = '0;
	logic [2:0]  acc_count     = '0;
	logic [31:0] stream_pos    = '0;
	logic [7:0]  escape_shadow = hcp_pkg::ESCAPE_RESET;

	packed_byte_t expected_bytes [$];

	// Stimulus bookkeeping: only symbols with a loaded entry may be encoded.
	bit          sym_loaded [hcp_pkg::SYMBOL_COUNT];
	logic [7:0]  loaded_syms [$];

	bit idle_on = 1'b1;
	int error_count = 0;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Queue one expected byte at the next stream position.
	task automatic emit_expected(input logic [7:0] data, input logic [2:0] pad,
		input logic is_last);
		packed_byte_t b;
		b.data = data;
		b.pos  = stream_pos;
		b.kept = (data != escape_shadow);
		b.pad  = pad;
		b.last = is_last;
		expected_bytes = {expected_bytes, b};
		stream_pos = stream_pos + 32'd1;
	endtask

	// Apply one accepted request to the shadow and queue the bytes it completes.
	task automatic pack_request(input logic [1:0] m, input logic [7:0] s,
		input logic [31:0] b, input logic [5:0] l);
		int unsigned ul;
		int unsigned total;
		int unsigned pad;
		logic [63:0] merged;
		case (m)
			hcp_pkg::MODE_LOAD: begin
				if (s < hcp_pkg::SYMBOL_COUNT) begin
					tbl_code[s] = b;
					tbl_len[s]  = l;
				end
			end
			hcp_pkg::MODE_ENCODE: begin
				if (s < hcp_pkg::SYMBOL_COUNT) begin
					ul = (tbl_len[s] > CODE_CAP) ? CODE_CAP : tbl_len[s];
					if (ul != 0) begin
						// pending bits on top, new code right-aligned below
						merged = ({57'd0, acc_bits} << ul) |
							({32'd0, tbl_code[s]} & ((64'd1 << ul) - 64'd1));
						total = acc_count + ul;
						while (total >= hcp_pkg::BYTE_BITS) begin
							total -= hcp_pkg::BYTE_BITS;
							emit_expected(8'(merged >> total), 3'd0,
								total < hcp_pkg::BYTE_BITS);
						end
						acc_bits  = 7'(merged & ((64'd1 << total) - 64'd1));
						acc_count = 3'(total);
					end
				end
			end
			hcp_pkg::MODE_FLUSH: begin
				// aligned flush is a no-op
				if (acc_count != 0) begin
					pad = hcp_pkg::BYTE_BITS - acc_count;
					emit_expected(8'({1'b0, acc_bits} << pad), 3'(pad), 1'b1);
					acc_bits  = '0;
					acc_count = '0;
				end
			end
			default: ;
		endcase
	endtask

	// Sampling process: predicts on every accepted request, checks every accepted
	// byte against the oldest expectation, and doubles as the hang watchdog.
	initial begin : monitor
		packed_byte_t want;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			quiet_cycles++;
			if (arst_n) begin
				if (cfg_valid && cfg_ready) begin
					escape_shadow = cfg_data;
					quiet_cycles = 0;
				end
				if (in_valid && !in_stall) begin
					pack_request(mode, symbol, code_bits, code_len);
					quiet_cycles = 0;
				end
				if (out_valid && !out_stall) begin
					quiet_cycles = 0;
					if (expected_bytes.size() == 0) begin
						$error("unexpected byte %02h at position %0d", out_byte,
							byte_position);
						error_count++;
					end else begin
						want = expected_bytes.pop_front();
						if (out_byte !== want.data) begin
							$error("out_byte: expected %02h, actual %02h", want.data, out_byte);
							error_count++;
						end
						if (byte_position !== want.pos) begin
							$error("byte_position: expected %0d, actual %0d", want.pos,
								byte_position);
							error_count++;
						end
						if (kept !== want.kept) begin
							$error("kept: expected %0b, actual %0b", want.kept, kept);
							error_count++;
						end
						if (pad_bits !== want.pad) begin
							$error("pad_bits: expected %0d, actual %0d", want.pad, pad_bits);
							error_count++;
						end
						if (last !== want.last) begin
							$error("last: expected %0b, actual %0b", want.last, last);
							error_count++;
						end
					end
				end
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Output back-pressure: random stall bursts while idling is on.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Send one request. Called at a falling edge, returns at a falling edge; valid
	// stays high into the next request unless an idle burst is drawn.
	task automatic send_request(input logic [1:0] m, input logic [7:0] s,
		input logic [31:0] b, input logic [5:0] l);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid  = 1'b1;
		mode      = m;
		symbol    = s;
		code_bits = b;
		code_len  = l;
		if (m == hcp_pkg::MODE_LOAD && !sym_loaded[s]) begin
			sym_loaded[s] = 1'b1;
			loaded_syms = {loaded_syms, s};
		end
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Quiesce the block: no request pending, all bytes out, pipeline empty.
	task automatic settle_block();
		in_valid = 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_escape(input logic [7:0] value);
		settle_block();
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One random request, weighted toward encodes of loaded symbols so that the
	// accumulator sees long runs of real traffic.
	task automatic random_request();
		int unsigned pick;
		logic [31:0] bits;
		logic [5:0]  len;
		pick = $urandom_range(0, 99);
		if (pick < 12 || loaded_syms.size() == 0) begin
			case ($urandom_range(0, 3))
				0:       bits = 32'h0000_0000;
				1:       bits = 32'hFFFF_FFFF;
				default: bits = $urandom;
			endcase
			case ($urandom_range(0, 9))
				0:       len = 6'd0;
				1:       len = 6'($urandom_range(33, 63));
				2:       len = 6'd32;
				default: len = 6'($urandom_range(1, 31));
			endcase
			send_request(hcp_pkg::MODE_LOAD, 8'($urandom), bits, len);
		end else if (pick < 82) begin
			// code fields ride along but must be ignored
			send_request(hcp_pkg::MODE_ENCODE,
				loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
				$urandom, 6'($urandom));
		end else if (pick < 95) begin
			send_request(hcp_pkg::MODE_FLUSH, 8'($urandom), $urandom, 6'($urandom));
		end else begin
			send_request(MODE_UNUSED, 8'($urandom), $urandom, 6'($urandom));
		end
	endtask

	// Reset escape value, field extremes, clipped and empty codes, every mode.
	task automatic test_codes_and_modes();
		send_request(hcp_pkg::MODE_LOAD, 8'h00, 32'h0000_0001, 6'd1);
		send_request(hcp_pkg::MODE_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
		send_request(hcp_pkg::MODE_LOAD, 8'h1A, 32'h0000_001A, 6'd8);  // packs to reset escape
		send_request(hcp_pkg::MODE_LOAD, 8'h80, 32'hDEAD_BEEF, 6'd0);  // empty code
		send_request(hcp_pkg::MODE_LOAD, 8'h55, 32'hA5A5_A5A5, 6'd63); // clipped to 32
		send_request(hcp_pkg::MODE_LOAD, 8'h2A, 32'h0000_0003, 6'd33);
		send_request(hcp_pkg::MODE_LOAD, 8'h01, 32'h1234_5678, 6'd7);  // upper bits ignored
		send_request(hcp_pkg::MODE_FLUSH, 8'h00, 32'h0, 6'd0);         // flush while aligned
		send_request(hcp_pkg::MODE_ENCODE, 8'h1A, 32'h0, 6'd0);        // byte equal to the escape, kept low
		send_request(hcp_pkg::MODE_ENCODE, 8'h00, 32'h0, 6'd0);
		send_request(hcp_pkg::MODE_ENCODE, 8'hFF, 32'h0, 6'd0);        // 1 + 32 bits
		send_request(hcp_pkg::MODE_ENCODE, 8'h01, 32'h0, 6'd0);        // lands on a boundary
		send_request(hcp_pkg::MODE_ENCODE, 8'h01, 32'h0, 6'd0);
		send_request(hcp_pkg::MODE_ENCODE, 8'h55, 32'h0, 6'd0);        // 7 + 32 bits
		send_request(hcp_pkg::MODE_ENCODE, 8'h80, 32'h0, 6'd0);        // empty code, no output
		send_request(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		send_request(hcp_pkg::MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63); // pad of one
		send_request(hcp_pkg::MODE_ENCODE, 8'h00, 32'h0, 6'd0);
		send_request(hcp_pkg::MODE_FLUSH, 8'h00, 32'h0, 6'd0);         // pad of seven
		send_request(hcp_pkg::MODE_ENCODE, 8'h2A, 32'h0, 6'd0);
		// reload then encode, back to back unless an idle burst is drawn: table write must be seen by the read
		send_request(hcp_pkg::MODE_LOAD, 8'h00, 32'h0000_0015, 6'd5);
		send_request(hcp_pkg::MODE_ENCODE, 8'h00, 32'h0, 6'd0);
		send_request(hcp_pkg::MODE_FLUSH, 8'h00, 32'h0, 6'd0);
	endtask

	// Escape at both ends of its range, with bytes built to hit it.
	task automatic test_escape_extremes();
		set_escape(8'h00);
		send_request(hcp_pkg::MODE_LOAD, 8'h10, 32'h0000_0000, 6'd8);
		send_request(hcp_pkg::MODE_ENCODE, 8'h10, 32'h0, 6'd0);
		send_request(hcp_pkg::MODE_ENCODE, 8'h10, 32'h0, 6'd0);
		set_escape(8'hFF);
		send_request(hcp_pkg::MODE_LOAD, 8'h11, 32'hFFFF_FFFF, 6'd16);
		send_request(hcp_pkg::MODE_ENCODE, 8'h11, 32'h0, 6'd0);
		send_request(hcp_pkg::MODE_ENCODE, 8'h10, 32'h0, 6'd0);
	endtask

	// Random traffic in phases, a different escape value for each.
	task automatic test_random_stream();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       set_escape(8'h00);
				1:       set_escape(8'hFF);
				default: set_escape(8'($urandom));
			endcase
			repeat (70) random_request();
		end
	endtask

	// Last stretch at full rate on both sides.
	task automatic test_quiet_tail();
		set_escape(8'($urandom));
		idle_on = 1'b0;
		repeat (40) random_request();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = hcp_pkg::MODE_LOAD;
		symbol    = '0;
		code_bits = '0;
		code_len  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		for (int i = 0; i < hcp_pkg::SYMBOL_COUNT; i++) begin
			tbl_code[i]   = '0;
			tbl_len[i]    = '0;
			sym_loaded[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_codes_and_modes();
		test_escape_extremes();
		test_random_stream();
		test_quiet_tail();

		// Drain, then watch a little longer for stray bytes.
		in_valid = 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/hcp_pkg.sv
hw/rtl/hcp_ram.sv
hw/rtl/hcp_emit.sv
hw/rtl/huffman_code_packer.sv
sim/testbench.sv
